>>> hdl/vib_pkg.sv
`timescale 1ns / 1ps

package vib_pkg;

   localparam int CHANNEL_BITS       = 16;
   localparam int FALLOFF_INDEX_BITS = 10;

   localparam int CH_W      = CHANNEL_BITS;
   localparam int FI_W      = FALLOFF_INDEX_BITS;
   localparam int ROM_DEPTH = 1 << FI_W;
   localparam int OFF_W     = 8;
   localparam int OFF_MAG_W = 7;
   localparam int OFF_LIMIT = 100;

   // q16 fixed-point scale of falloff and strength
   localparam int Q_FRAC  = 16;
   localparam int FALL_W  = Q_FRAC + 1;
   localparam int LUM_W   = CH_W + Q_FRAC;
   localparam int SUM_W   = CH_W + 2;

   localparam logic [Q_FRAC-1:0] LUMA_WT_R = 16'd19595;
   localparam logic [Q_FRAC-1:0] LUMA_WT_G = 16'd38470;
   localparam logic [Q_FRAC-1:0] LUMA_WT_B = 16'd7471;

   localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

   typedef logic [2:0][CH_W-1:0] pixel_type;

   typedef struct packed {
      logic                  valid;
      logic                  neg;
      logic [OFF_MAG_W-1:0]  off_mag;
      logic [FI_W-1:0]       k;
      pixel_type             chan;
      logic [LUM_W-1:0]      lum;
      logic [SUM_W-1:0]      sum;
   } front_type;

   typedef struct packed {
      logic                  valid;
      logic                  neg;
      logic [FALL_W-1:0]     t_mag;
      pixel_type             chan;
      logic [LUM_W-1:0]      lum;
      logic [SUM_W-1:0]      sum;
   } strength_type;

   typedef logic [FALL_W-1:0] falloff_rom_type [ROM_DEPTH];

   // rounded (a * b) >> 62
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << 61);
      return p[62 +: 64];
   endfunction

   // exp(-3k/depth) in q16, built from a q62 taylor step and repeated products
   function automatic falloff_rom_type build_falloff_rom();
      falloff_rom_type rom;
      logic [63:0]     y;
      logic [63:0]     term;
      logic [63:0]     step;
      logic [63:0]     acc;
      logic [63:0]     rnd;
      y    = 64'd3 << (62 - FI_W);
      term = 64'd1 << 62;
      step = 64'd1 << 62;
      for (int n = 1; n <= 24; n++) begin
         term = mul_q62(term, y) / 64'(n);
         if (n % 2 == 1) begin
            step = step - term;
         end else begin
            step = step + term;
         end
      end
      acc = 64'd1 << 62;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         rnd    = acc + (64'd1 << 45);
         rom[k] = rnd[46 +: FALL_W];
         acc    = mul_q62(acc, step);
      end
      return rom;
   endfunction

   localparam falloff_rom_type FALLOFF_ROM = build_falloff_rom();

endpackage

>>> hdl/vib_front.sv
`timescale 1ns / 1ps

module vib_front
   import vib_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_i,
   input  pixel_type               chan_i,
   input  logic signed [OFF_W-1:0] offset_i,
   output front_type               front_o
);

   front_type                front_ff;
   front_type                front_in;
   logic [CH_W-1:0]          mx;
   logic [CH_W-1:0]          mn;
   logic [CH_W-1:0]          chroma;
   logic [CH_W+FI_W-1:0]     chroma_sh;
   logic signed [OFF_W-1:0]  off_abs;

   always_comb begin
      mx = chan_i[0];
      mn = chan_i[0];
      for (int i = 1; i < 3; i++) begin
         if (chan_i[i] > mx) mx = chan_i[i];
         if (chan_i[i] < mn) mn = chan_i[i];
      end
      chroma    = mx - mn;
      // top index bits of chroma, zero filled when chroma is narrower
      chroma_sh = {chroma, {FI_W{1'b0}}};

      off_abs = offset_i[OFF_W-1] ? -offset_i : offset_i;

      front_in.valid = valid_i;
      front_in.neg   = offset_i[OFF_W-1];
      if (offset_i > OFF_W'(OFF_LIMIT) || offset_i < -OFF_W'(OFF_LIMIT)) begin
         front_in.off_mag = OFF_MAG_W'(OFF_LIMIT);
      end else begin
         front_in.off_mag = off_abs[OFF_MAG_W-1:0];
      end
      front_in.k    = chroma_sh[CH_W +: FI_W];
      front_in.chan = chan_i;
      front_in.lum  = LUM_W'(chan_i[0]) * LUM_W'(LUMA_WT_R)
                    + LUM_W'(chan_i[1]) * LUM_W'(LUMA_WT_G)
                    + LUM_W'(chan_i[2]) * LUM_W'(LUMA_WT_B);
      front_in.sum  = SUM_W'(chan_i[0]) + SUM_W'(chan_i[1]) + SUM_W'(chan_i[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
      end else begin
         front_ff <= front_in;
      end
   end

   assign front_o = front_ff;

endmodule

>>> hdl/vib_strength.sv
`timescale 1ns / 1ps

module vib_strength
   import vib_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  front_type    front_i,
   output strength_type strength_o
);

   localparam int PROD_W  = OFF_MAG_W + FALL_W;
   // divide by 100 as multiply by ceil(2^30/100), exact over the product range
   localparam int DIV_SH  = 30;
   localparam int RECIP_W = 24;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << DIV_SH) / 100) + 1);

   typedef struct packed {
      logic                  valid;
      logic                  neg;
      logic [OFF_MAG_W-1:0]  off_mag;
      logic [FALL_W-1:0]     falloff;
      pixel_type             chan;
      logic [LUM_W-1:0]      lum;
      logic [SUM_W-1:0]      sum;
   } rom_stage_type;

   typedef struct packed {
      logic                  valid;
      logic                  neg;
      logic [PROD_W-1:0]     prod;
      pixel_type             chan;
      logic [LUM_W-1:0]      lum;
      logic [SUM_W-1:0]      sum;
   } prod_stage_type;

   rom_stage_type              s2_ff;
   rom_stage_type              s2_in;
   prod_stage_type             s3_ff;
   prod_stage_type             s3_in;
   strength_type               s4_ff;
   strength_type               s4_in;
   logic [PROD_W+RECIP_W-1:0]  quot_wide;

   always_comb begin
      s2_in.valid   = front_i.valid;
      s2_in.neg     = front_i.neg;
      s2_in.off_mag = front_i.off_mag;
      s2_in.falloff = FALLOFF_ROM[front_i.k];
      s2_in.chan    = front_i.chan;
      s2_in.lum     = front_i.lum;
      s2_in.sum     = front_i.sum;

      s3_in.valid = s2_ff.valid;
      s3_in.neg   = s2_ff.neg;
      s3_in.prod  = PROD_W'(s2_ff.off_mag) * PROD_W'(s2_ff.falloff) + PROD_W'(50);
      s3_in.chan  = s2_ff.chan;
      s3_in.lum   = s2_ff.lum;
      s3_in.sum   = s2_ff.sum;

      quot_wide   = (PROD_W+RECIP_W)'(s3_ff.prod) * (PROD_W+RECIP_W)'(RECIP_100);
      s4_in.valid = s3_ff.valid;
      s4_in.neg   = s3_ff.neg;
      s4_in.t_mag = quot_wide[DIV_SH +: FALL_W];
      s4_in.chan  = s3_ff.chan;
      s4_in.lum   = s3_ff.lum;
      s4_in.sum   = s3_ff.sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
      end else begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign strength_o = s4_ff;

endmodule

>>> hdl/vib_mix.sv
`timescale 1ns / 1ps

module vib_mix
   import vib_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  strength_type strength_i,
   output logic         valid_o,
   output pixel_type    chan_o
);

   localparam int A_W   = LUM_W + 1;
   localparam int B_W   = FALL_W + 2;
   localparam int P_W   = A_W + B_W;
   localparam int NUM_W = P_W + 1;
   localparam int POS_W = NUM_W - 2 * Q_FRAC;
   localparam int QI_W  = CH_W + 2;
   // divide by 3 as multiply by ceil(2^K3/3), exact below 2^(K3-1)
   localparam int K3    = QI_W + 1;
   localparam int R3_W  = K3;
   localparam logic [R3_W-1:0] RECIP_3 = R3_W'(((64'd1 << K3) / 3) + 1);
   localparam logic [NUM_W-1:0] HALF_POS = NUM_W'(64'd1 << (2 * Q_FRAC - 1));
   localparam logic [NUM_W-1:0] HALF_NEG = NUM_W'((64'd3 << Q_FRAC) / 2);
   localparam logic [B_W-1:0]   Q_ONE    = B_W'(64'd1 << Q_FRAC);

   logic                    v5_ff, v6_ff, v7_ff, v8_ff;
   logic                    n5_ff, n6_ff, n7_ff;
   logic signed [A_W-1:0]   a_ff    [3];
   logic signed [A_W-1:0]   a_in    [3];
   logic signed [B_W-1:0]   b_ff;
   logic signed [B_W-1:0]   b_in;
   logic [NUM_W-1:0]        base5_ff [3];
   logic [NUM_W-1:0]        base5_in [3];
   logic [NUM_W-1:0]        base6_ff [3];
   logic signed [P_W-1:0]   prod_ff [3];
   logic signed [P_W-1:0]   prod_in [3];
   logic [NUM_W-1:0]        z_ff    [3];
   logic [NUM_W-1:0]        z_in    [3];
   pixel_type               out_ff;
   pixel_type               out_in;
   logic [SUM_W-1:0]        c3;
   logic signed [POS_W-1:0] y_pos;
   logic [QI_W-1:0]         y_neg;
   logic [QI_W+R3_W-1:0]    q_wide;
   logic [CH_W:0]           q_neg;

   // operand select: away from luma or toward the average
   always_comb begin
      if (strength_i.neg) begin
         b_in = $signed(B_W'(strength_i.t_mag));
      end else begin
         b_in = $signed(Q_ONE + B_W'(strength_i.t_mag));
      end
      for (int i = 0; i < 3; i++) begin
         c3 = SUM_W'({strength_i.chan[i], 1'b0}) + SUM_W'(strength_i.chan[i]);
         if (strength_i.neg) begin
            a_in[i]     = $signed(A_W'(strength_i.sum)) - $signed(A_W'(c3));
            base5_in[i] = NUM_W'({c3, {Q_FRAC{1'b0}}});
         end else begin
            a_in[i]     = $signed(A_W'({strength_i.chan[i], {Q_FRAC{1'b0}}}))
                        - $signed(A_W'(strength_i.lum));
            base5_in[i] = NUM_W'({strength_i.lum, {Q_FRAC{1'b0}}});
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = P_W'(a_ff[i]) * P_W'(b_ff);
         z_in[i]    = base6_ff[i] + NUM_W'(prod_ff[i]) + (n6_ff ? HALF_NEG : HALF_POS);
      end
   end

   // final scaling and saturation
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         y_pos  = $signed(z_ff[i][NUM_W-1 -: POS_W]);
         y_neg  = z_ff[i][Q_FRAC +: QI_W];
         q_wide = (QI_W+R3_W)'(y_neg) * (QI_W+R3_W)'(RECIP_3);
         q_neg  = q_wide[K3 +: CH_W+1];
         if (n7_ff) begin
            out_in[i] = (q_neg > (CH_W+1)'(CH_MAX)) ? CH_MAX : q_neg[CH_W-1:0];
         end else if (y_pos[POS_W-1]) begin
            out_in[i] = '0;
         end else if (y_pos > $signed(POS_W'(CH_MAX))) begin
            out_in[i] = CH_MAX;
         end else begin
            out_in[i] = y_pos[CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v5_ff <= strength_i.valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      n5_ff  <= strength_i.neg;
      n6_ff  <= n5_ff;
      n7_ff  <= n6_ff;
      b_ff   <= b_in;
      out_ff <= out_in;
      for (int i = 0; i < 3; i++) begin
         a_ff[i]     <= a_in[i];
         base5_ff[i] <= base5_in[i];
         base6_ff[i] <= base5_ff[i];
         prod_ff[i]  <= prod_in[i];
         z_ff[i]     <= z_in[i];
      end
   end

   assign valid_o = v8_ff;
   assign chan_o  = out_ff;

endmodule

>>> hdl/pixel_vibrance_adjust_top.sv
`timescale 1ns / 1ps
// a word taken with start passes through the stages listed below to the rsp_ ports
// throughput: one pixel per cycle, busy stays low, so start may be held high
// the eight stages are the front end, the falloff rom, strength multiply,
// strength divide, operand select, channel multiply, add and final scaling
// reset clears all pipeline valid bits and sets the vibrance offset to 0
// the receiver cannot stall: rsp_valid marks each result for one cycle
module pixel_vibrance_adjust_top
   import vib_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CH_W-1:0]         req_red_in,
   input  logic [CH_W-1:0]         req_green_in,
   input  logic [CH_W-1:0]         req_blue_in,
   output logic                    rsp_valid,
   output logic [CH_W-1:0]         rsp_red_out,
   output logic [CH_W-1:0]         rsp_green_out,
   output logic [CH_W-1:0]         rsp_blue_out,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic signed [OFF_W-1:0] csr_wdata
);

   logic signed [OFF_W-1:0] offset_ff;
   logic signed [OFF_W-1:0] offset_in;
   pixel_type               req_chan;
   pixel_type               rsp_chan;
   front_type               front;
   strength_type            strength;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign offset_in = (csr_valid && csr_ready) ? csr_wdata : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   assign req_chan[0] = req_red_in;
   assign req_chan[1] = req_green_in;
   assign req_chan[2] = req_blue_in;

   vib_front u_front (
      .clock    (clock),
      .reset    (reset),
      .valid_i  (start && !busy),
      .chan_i   (req_chan),
      .offset_i (offset_ff),
      .front_o  (front)
   );

   vib_strength u_strength (
      .clock      (clock),
      .reset      (reset),
      .front_i    (front),
      .strength_o (strength)
   );

   vib_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .strength_i (strength),
      .valid_o    (rsp_valid),
      .chan_o     (rsp_chan)
   );

   assign rsp_red_out   = rsp_chan[0];
   assign rsp_green_out = rsp_chan[1];
   assign rsp_blue_out  = rsp_chan[2];

endmodule

>>> tb/pixel_vibrance_adjust_top_tb.sv
`timescale 1ns / 1ps

module pixel_vibrance_adjust_top_tb
   import vib_pkg::*;
();

   localparam int LATENCY     = 8;
   localparam int PHASE_ITEMS = 98;

   typedef struct {
      pixel_type        rgb_in;
      logic signed [7:0] offset;
      pixel_type        rgb_out;
   } pixel_expect_type;

   class vibrance_board;
      logic [FALL_W-1:0]  falloff_q16 [ROM_DEPTH];
      logic signed [7:0]  offset_reg;
      pixel_expect_type   expected_pixels [$];
      int                 mismatches;

      function new();
         offset_reg = '0;
         mismatches = 0;
         build_falloff();
      endfunction

      // rounded (a * b) >> 62
      function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         p = p + (128'd1 << 61);
         return p[125:62];
      endfunction

      // exp(-3k/depth) in q16, from a taylor-series step applied repeatedly
      function void build_falloff();
         logic [63:0] y;
         logic [63:0] term;
         logic [63:0] step;
         logic [63:0] acc;
         logic [63:0] rounded;
         y    = 64'd3 << (62 - FI_W);
         term = 64'd1 << 62;
         step = 64'd1 << 62;
         for (int n = 1; n <= 24; n++) begin
            term = q62_product(term, y) / 64'(n);
            if (n % 2 == 1) begin
               step = step - term;
            end else begin
               step = step + term;
            end
         end
         acc = 64'd1 << 62;
         for (int k = 0; k < ROM_DEPTH; k++) begin
            rounded        = acc + (64'd1 << 45);
            falloff_q16[k] = rounded[46 +: FALL_W];
            acc            = q62_product(acc, step);
         end
      endfunction

      function automatic logic [CH_W-1:0] clip_channel(input longint num, input longint half,
                                                       input longint div);
         longint q;
         if (num < 0) begin
            return '0;
         end
         q = (num + half) / div;
         if (q > longint'(CH_MAX)) begin
            return CH_MAX;
         end
         return q[CH_W-1:0];
      endfunction

      function automatic pixel_type adjust_pixel(input pixel_type rgb, input logic signed [7:0] o);
         pixel_type      res;
         longint         c [3];
         longint         mx;
         longint         mn;
         longint         off;
         longint         mag;
         longint         t;
         longint         lum;
         longint         s;
         longint         d;
         logic [CH_W-1:0] chroma;
         logic [FI_W-1:0] k;
         for (int i = 0; i < 3; i++) begin
            c[i] = longint'(rgb[i]);
         end
         mx = c[0];
         mn = c[0];
         for (int i = 1; i < 3; i++) begin
            if (c[i] > mx) mx = c[i];
            if (c[i] < mn) mn = c[i];
         end
         chroma = CH_W'(mx - mn);
         k      = chroma[CH_W-1 -: FI_W];
         off    = longint'(o);
         if (off > OFF_LIMIT) off = OFF_LIMIT;
         if (off < -OFF_LIMIT) off = -OFF_LIMIT;
         mag = ((off < 0 ? -off : off) * longint'(falloff_q16[k]) + 50) / 100;
         t   = (off < 0) ? -mag : mag;
         if (off >= 0) begin
            lum = longint'(LUMA_WT_R) * c[0] + longint'(LUMA_WT_G) * c[1]
                + longint'(LUMA_WT_B) * c[2];
            for (int i = 0; i < 3; i++) begin
               d      = c[i] * 65536 - lum;
               res[i] = clip_channel(lum * 65536 + d * (65536 + t), 64'sd1 << 31, 64'sd1 << 32);
            end
         end else begin
            s = c[0] + c[1] + c[2];
            for (int i = 0; i < 3; i++) begin
               res[i] = clip_channel(3 * c[i] * 65536 + (s - 3 * c[i]) * (-t), 98304, 196608);
            end
         end
         return res;
      endfunction

      function void set_offset(input logic signed [7:0] v);
         offset_reg = v;
      endfunction

      function void note_pixel(input pixel_type rgb);
         pixel_expect_type e;
         e.rgb_in  = rgb;
         e.offset  = offset_reg;
         e.rgb_out = adjust_pixel(rgb, offset_reg);
         expected_pixels.push_back(e);
      endfunction

      function void check_pixel(input pixel_type rgb);
         pixel_expect_type e;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected pixel out %h %h %h", rgb[0], rgb[1], rgb[2]);
            end
            return;
         end
         e = expected_pixels.pop_front();
         if (rgb[0] !== e.rgb_out[0] || rgb[1] !== e.rgb_out[1] || rgb[2] !== e.rgb_out[2]) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: in %h %h %h offset %0d expected %h %h %h got %h %h %h",
                        e.rgb_in[0], e.rgb_in[1], e.rgb_in[2], e.offset,
                        e.rgb_out[0], e.rgb_out[1], e.rgb_out[2], rgb[0], rgb[1], rgb[2]);
            end
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CH_W-1:0]         req_red_in = '0;
   logic [CH_W-1:0]         req_green_in = '0;
   logic [CH_W-1:0]         req_blue_in = '0;
   logic                    rsp_valid;
   logic [CH_W-1:0]         rsp_red_out;
   logic [CH_W-1:0]         rsp_green_out;
   logic [CH_W-1:0]         rsp_blue_out;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic signed [OFF_W-1:0] csr_wdata = '0;

   vibrance_board sb;
   bit            no_gaps;

   pixel_vibrance_adjust_top u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .rsp_valid    (rsp_valid),
      .rsp_red_out  (rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out (rsp_blue_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // a word taken at the same edge as a register write still sees the old offset
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_pixel({req_blue_in, req_green_in, req_red_in});
         end
         if (csr_valid && csr_ready) begin
            sb.set_offset(csr_wdata);
         end
         if (rsp_valid) begin
            sb.check_pixel({rsp_blue_out, rsp_green_out, rsp_red_out});
         end
      end
   end

   function automatic int pick_gap();
      int sel;
      if (no_gaps) begin
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type  rgb;
      logic [CH_W-1:0] lo;
      logic [CH_W-1:0] hi;
      int         span;
      int         sel;
      int         first;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         for (int i = 0; i < 3; i++) rgb[i] = CH_W'($urandom());
      end else if (sel < 6) begin
         // nearly grey, small chroma
         lo = CH_W'($urandom());
         for (int i = 0; i < 3; i++) begin
            span   = int'(lo) + $urandom_range(0, 300) - 150;
            rgb[i] = (span < 0) ? '0 : (span > 65535) ? CH_MAX : CH_W'(span);
         end
      end else if (sel < 7) begin
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 2))
               0: rgb[i] = '0;
               1: rgb[i] = CH_MAX;
               default: rgb[i] = CH_W'($urandom());
            endcase
         end
      end else begin
         // spread chroma over the whole falloff table
         lo    = CH_W'($urandom());
         span  = $urandom_range(0, 65535) >> $urandom_range(0, 10);
         hi    = (int'(lo) + span > 65535) ? CH_MAX : CH_W'(int'(lo) + span);
         first = $urandom_range(0, 2);
         rgb[first]           = hi;
         rgb[(first + 1) % 3] = lo;
         rgb[(first + 2) % 3] = CH_W'($urandom_range(int'(lo), int'(hi)));
      end
      return rgb;
   endfunction

   task automatic write_offset(input logic signed [7:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drive_pixel(input pixel_type rgb);
      int gap;
      start        <= 1'b1;
      req_red_in   <= rgb[0];
      req_green_in <= rgb[1];
      req_blue_in  <= rgb[2];
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (sb.pending() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic run_directed();
      pixel_type cases [12];
      cases[0]  = {16'h0000, 16'h0000, 16'h0000};
      cases[1]  = {16'hFFFF, 16'hFFFF, 16'hFFFF};
      cases[2]  = {16'h0000, 16'h0000, 16'hFFFF};
      cases[3]  = {16'h0000, 16'hFFFF, 16'h0000};
      cases[4]  = {16'hFFFF, 16'h0000, 16'h0000};
      cases[5]  = {16'h8000, 16'h8000, 16'h8000};
      cases[6]  = {16'h0000, 16'hFFFF, 16'hFFFF};
      cases[7]  = {16'hFFFF, 16'hFFFF, 16'h0000};
      // chroma just at and just below the first table step
      cases[8]  = {16'h0000, 16'h0000, 16'h0040};
      cases[9]  = {16'h0000, 16'h0000, 16'h003F};
      cases[10] = {16'h5678, 16'hABCD, 16'h1234};
      // bright, strongly coloured: pushes one channel below zero
      cases[11] = {16'h0800, 16'hE000, 16'hF000};
      foreach (cases[i]) drive_pixel(cases[i]);
   endtask

   initial begin
      logic signed [7:0] offsets [12];
      sb       = new();
      no_gaps  = 1'b0;
      offsets  = '{8'sd0, 8'sd127, -8'sd128, 8'sd1, -8'sd1, 8'sd100, -8'sd100,
                   8'sd50, -8'sd50, 8'sd0, 8'sd0, 8'sd0};
      offsets[9]  = 8'($urandom_range(0, 255));
      offsets[10] = 8'($urandom_range(0, 255));
      offsets[11] = 8'($urandom_range(0, 255));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_offset(8'sd100);
      run_directed();
      wait_drained();
      write_offset(-8'sd100);
      run_directed();
      wait_drained();

      foreach (offsets[p]) begin
         write_offset(offsets[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0) begin
               no_gaps = ($urandom_range(0, 3) == 0);
            end
            drive_pixel(random_pixel());
         end
         no_gaps = 1'b0;
         wait_drained();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         if (sb.pending() != 0) begin
            $display("%0d expected pixels never arrived", sb.pending());
         end
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout");
      $display("Some tests failed");
      $finish;
   end

endmodule
